### hdl/lus_pkg.sv
// Shared types, constants and arithmetic helpers for the dense LU solver.
`default_nettype none
package lus_pkg;

	localparam int MAX_ORDER_DEF = 16;
	localparam int IDX_W = 4;
	localparam int ORDER_W = 5;
	localparam int ORDER_LIMIT = 16;
	localparam int FRAC_W = 16;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef enum logic [1:0] {
		MODE_MATRIX = 2'd0,
		MODE_RHS    = 2'd1,
		MODE_SOLVE  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Command word from the controller to the datapath.
	typedef struct packed {
		logic             ld_m;
		logic             ld_r;
		logic             rd;
		logic [IDX_W-1:0] a_row;
		logic [IDX_W-1:0] a_col;
		logic [IDX_W-1:0] b_row;
		logic [IDX_W-1:0] b_col;
		logic [IDX_W-1:0] r_idx;
		logic             b_rhs;
		logic             mul;
		logic             acc_clr;
		logic             acc_add;
		logic             tgt_rhs;
		logic             diff;
		logic             div_start;
		logic             wr;
		logic             wr_div;
		logic             err_clr;
		logic             out_load;
		logic             out_last;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	// Drops the fraction bits of a product, rounding toward zero.
	function automatic logic signed [63:0] q_scale(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = p >>> FRAC_W;
		if (p[63] && (p[FRAC_W-1:0] != '0)) begin
			r = r + 64'sd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/lus_item_if.sv
// Input item channel of the LU solver.
`default_nettype none
interface lus_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [3:0]  row_index;
	logic [3:0]  col_index;
	logic signed [31:0] value;

	modport source (output valid, mode, row_index, col_index, value, input ready);
	modport sink (input valid, mode, row_index, col_index, value, output ready);
endinterface
`default_nettype wire

### hdl/lus_result_if.sv
// Solution element channel of the LU solver.
`default_nettype none
interface lus_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  solution_index;
	logic signed [31:0] solution_value;
	logic        zero_pivot;
	logic        last;

	modport source (output valid, solution_index, solution_value, zero_pivot, last,
		input ready);
	modport sink (input valid, solution_index, solution_value, zero_pivot, last,
		output ready);
endinterface
`default_nettype wire

### hdl/lus_cfg_if.sv
// Configuration write channel carrying the system order.
`default_nettype none
interface lus_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### hdl/dense_lu_linear_solver_top.sv
// Dense linear system solver top level: Doolittle LU without pivoting in Q16.16.
// Load transactions (matrix entry or right-hand side entry) are taken while idle.
// A solve transaction stalls the input while the sequencer factors the matrix in
// place, runs forward and back substitution, and then delivers n solution
// transactions, the final one marked last. Every element update clears the
// accumulator, does a read, multiply and accumulate step per term on the single
// shared multiplier, subtracts the sum from its target and, when it divides by
// a pivot, runs the 48-step restoring divider. A zero pivot makes the
// quotient 0 and raises zero_pivot on every element of that solve. The matrix
// is not restored, so a repeated solve works on the factored matrix and the
// previous solution. Configure system_order only while the block is idle.
`default_nettype none
module dense_lu_linear_solver_top #(
	parameter int MAX_ORDER = lus_pkg::MAX_ORDER_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lus_item_if.sink      items,
	lus_cfg_if.sink       cfg,
	lus_result_if.source  results
);
	import lus_pkg::*;

	cmd_t    cmd;
	status_t status;

	lus_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.cfg    (cfg),
		.status (status),
		.cmd    (cmd)
	);

	lus_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_row   (items.row_index),
		.in_col   (items.col_index),
		.in_value (items.value),
		.results  (results)
	);
endmodule
`default_nettype wire

### hdl/lus_div.sv
// Iterative restoring divider for Q16.16 quotients, one quotient bit per cycle.
`default_nettype none
module lus_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic signed [31:0] num,
	input  wire logic signed [31:0] den,
	output logic                   busy,
	output logic signed [31:0]     quo
);
	import lus_pkg::*;

	localparam int NW = 32 + FRAC_W;

	logic          busy_q;
	logic          fin_q;
	logic [5:0]    cnt_q;
	logic [32:0]   rem_q;
	logic [NW-1:0] nq_q;
	logic [31:0]   d_q;
	logic          neg_q;

	logic [32:0] rem_sh;
	logic        take;
	logic [31:0] abs_n;
	logic [31:0] abs_d;

	assign abs_n = num[31] ? 32'(-num) : 32'(num);
	assign abs_d = den[31] ? 32'(-den) : 32'(den);
	assign rem_sh = {rem_q[31:0], nq_q[NW-1]};
	assign take = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= (den != '0);
			fin_q <= 1'b0;
			cnt_q <= 6'(NW - 1);
		end else if (busy_q && fin_q) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				fin_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q <= {abs_n, {FRAC_W{1'b0}}};
			d_q <= abs_d;
			neg_q <= num[31] ^ den[31];
			if (den == '0) begin
				quo <= '0;
			end
		end else if (busy_q && fin_q) begin
			if (!neg_q) begin
				quo <= (nq_q > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(nq_q);
			end else begin
				quo <= (nq_q > NW'(33'h080000000)) ? 32'sh80000000 : 32'(-nq_q);
			end
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - {1'b0, d_q}) : rem_sh;
			nq_q <= {nq_q[NW-2:0], take};
		end
	end

	assign busy = busy_q;
endmodule
`default_nettype wire

### hdl/lus_datapath.sv
// Matrix and right-hand side memories, multiply-accumulate, divider and result register.
`default_nettype none
module lus_datapath #(
	parameter int MAX_ORDER = lus_pkg::MAX_ORDER_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lus_pkg::cmd_t  cmd,
	output lus_pkg::status_t    status,
	input  wire logic [3:0]     in_row,
	input  wire logic [3:0]     in_col,
	input  wire logic signed [31:0] in_value,
	lus_result_if.source        results
);
	import lus_pkg::*;

	localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
	localparam int RW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	logic signed [31:0] mat_mem [MAX_ORDER*MAX_ORDER];
	logic signed [31:0] rhs_mem [MAX_ORDER];

	logic signed [31:0] ma_q;
	logic signed [31:0] mb_q;
	logic signed [31:0] rv_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] diff_q;
	logic               err_q;
	logic               ov_q;

	logic signed [31:0] bop;
	logic signed [31:0] tgt;
	logic signed [31:0] res;
	logic signed [31:0] quo;
	logic               div_busy;
	logic               in_range;

	function automatic logic [AW-1:0] mat_addr(input logic [3:0] r, input logic [3:0] c);
		return AW'(32'(r) * MAX_ORDER + 32'(c));
	endfunction

	assign in_range = (32'(in_row) < MAX_ORDER) && (32'(in_col) < MAX_ORDER);
	assign bop = cmd.b_rhs ? rv_q : mb_q;
	assign tgt = cmd.tgt_rhs ? rv_q : ma_q;
	assign res = cmd.wr_div ? quo : diff_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_m && in_range) begin
			mat_mem[mat_addr(in_row, in_col)] <= in_value;
		end else if (cmd.wr && !cmd.tgt_rhs) begin
			mat_mem[mat_addr(cmd.a_row, cmd.a_col)] <= res;
		end
		if (cmd.ld_r && (32'(in_row) < MAX_ORDER)) begin
			rhs_mem[RW'(in_row)] <= in_value;
		end else if (cmd.wr && cmd.tgt_rhs) begin
			rhs_mem[RW'(cmd.r_idx)] <= res;
		end
		if (cmd.rd) begin
			ma_q <= mat_mem[mat_addr(cmd.a_row, cmd.a_col)];
			mb_q <= mat_mem[mat_addr(cmd.b_row, cmd.b_col)];
			rv_q <= rhs_mem[RW'(cmd.r_idx)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= ma_q * bop;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + q_scale(prod_q);
		end
		if (cmd.diff) begin
			diff_q <= sat32(64'(tgt) - acc_q);
		end
	end

	lus_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (diff_q),
		.den    (mb_q),
		.busy   (div_busy),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.err_clr) begin
				err_q <= 1'b0;
			end else if (cmd.div_start && (mb_q == '0)) begin
				err_q <= 1'b1;
			end
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			results.solution_index <= cmd.r_idx;
			results.solution_value <= rv_q;
			results.zero_pivot <= err_q;
			results.last <= cmd.out_last;
		end
	end

	assign results.valid = ov_q;
	assign status.div_busy = div_busy;
	assign status.out_free = !ov_q || results.ready;
endmodule
`default_nettype wire

### hdl/lus_ctrl.sv
// Sequencer for loading, factorization, substitution and result delivery.
`default_nettype none
module lus_ctrl #(
	parameter int MAX_ORDER = lus_pkg::MAX_ORDER_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	lus_item_if.sink              items,
	lus_cfg_if.sink               cfg,
	input  wire lus_pkg::status_t status,
	output lus_pkg::cmd_t         cmd
);
	import lus_pkg::*;

	localparam int CAP = (MAX_ORDER < ORDER_LIMIT) ? MAX_ORDER : ORDER_LIMIT;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_ELEM    = 12'b000000000010,
		S_T_RD    = 12'b000000000100,
		S_T_MUL   = 12'b000000001000,
		S_T_ACC   = 12'b000000010000,
		S_G_RD    = 12'b000000100000,
		S_G_DIFF  = 12'b000001000000,
		S_D_START = 12'b000010000000,
		S_D_WAIT  = 12'b000100000000,
		S_WRITE   = 12'b001000000000,
		S_E_RD    = 12'b010000000000,
		S_E_OUT   = 12'b100000000000
	} state_t;

	typedef enum logic [2:0] {
		PH_LU  = 3'b001,
		PH_FWD = 3'b010,
		PH_BCK = 3'b100
	} phase_t;

	state_t               state_q;
	phase_t               phase_q;
	logic [ORDER_W-1:0]   order_q;
	logic [IDX_W-1:0]     nm1_q;
	logic [IDX_W-1:0]     i_q;
	logic [IDX_W-1:0]     j_q;
	logic [IDX_W-1:0]     k_q;

	logic               take;
	logic [ORDER_W-1:0] n_eff;
	logic [IDX_W-1:0]   lim;
	logic [IDX_W-1:0]   k_first;
	logic               have_terms;
	logic               k_last;
	logic               use_div;
	logic               term;

	assign items.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign take = items.valid && items.ready;

	always_comb begin
		if (order_q == '0) begin
			n_eff = ORDER_W'(1);
		end else if (32'(order_q) > CAP) begin
			n_eff = ORDER_W'(CAP);
		end else begin
			n_eff = order_q;
		end
	end

	assign lim = (i_q < j_q) ? i_q : j_q;

	always_comb begin
		unique case (phase_q)
			PH_LU: begin
				k_first = '0;
				have_terms = (lim != '0);
				k_last = (k_q == lim - IDX_W'(1));
				use_div = (i_q > j_q);
			end
			PH_FWD: begin
				k_first = '0;
				have_terms = 1'b1;
				k_last = (k_q == i_q - IDX_W'(1));
				use_div = 1'b0;
			end
			PH_BCK: begin
				k_first = i_q + IDX_W'(1);
				have_terms = (i_q != nm1_q);
				k_last = (k_q == nm1_q);
				use_div = 1'b1;
			end
			default: begin
				k_first = '0;
				have_terms = 1'b0;
				k_last = 1'b1;
				use_div = 1'b0;
			end
		endcase
	end

	assign term = (state_q == S_T_RD) || (state_q == S_T_MUL) || (state_q == S_T_ACC);

	always_comb begin
		cmd = '0;
		cmd.ld_m = take && (items.mode == MODE_MATRIX);
		cmd.ld_r = take && (items.mode == MODE_RHS);
		cmd.err_clr = take && (items.mode == MODE_SOLVE);
		cmd.a_row = i_q;
		cmd.a_col = term ? k_q : j_q;
		cmd.r_idx = term ? k_q : i_q;
		// B is U(k,j) in LU terms and the diagonal pivot outside the term states.
		cmd.b_row = term ? k_q : ((phase_q == PH_LU) ? j_q : i_q);
		cmd.b_col = term ? j_q : ((phase_q == PH_LU) ? j_q : i_q);
		cmd.b_rhs = (phase_q != PH_LU);
		cmd.tgt_rhs = (phase_q != PH_LU) || (state_q == S_E_RD) || (state_q == S_E_OUT);
		cmd.wr_div = use_div;
		cmd.out_last = (i_q == nm1_q);
		unique case (state_q)
			S_IDLE:    ;
			S_ELEM:    cmd.acc_clr = 1'b1;
			S_T_RD:    cmd.rd = 1'b1;
			S_T_MUL:   cmd.mul = 1'b1;
			S_T_ACC:   cmd.acc_add = 1'b1;
			S_G_RD:    cmd.rd = 1'b1;
			S_G_DIFF:  cmd.diff = 1'b1;
			S_D_START: cmd.div_start = 1'b1;
			S_D_WAIT:  ;
			S_WRITE:   cmd.wr = 1'b1;
			S_E_RD:    cmd.rd = 1'b1;
			S_E_OUT:   cmd.out_load = status.out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_LU;
			order_q <= ORDER_W'(ORDER_LIMIT);
			nm1_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (cfg.valid) begin
				order_q <= cfg.data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take && (items.mode == MODE_SOLVE)) begin
						nm1_q <= IDX_W'(n_eff - ORDER_W'(1));
						j_q <= '0;
						if (n_eff == ORDER_W'(1)) begin
							phase_q <= PH_BCK;
							i_q <= '0;
						end else begin
							phase_q <= PH_LU;
							i_q <= IDX_W'(1);
						end
						state_q <= S_ELEM;
					end
				end
				S_ELEM: begin
					k_q <= k_first;
					state_q <= have_terms ? S_T_RD : S_G_RD;
				end
				S_T_RD:  state_q <= S_T_MUL;
				S_T_MUL: state_q <= S_T_ACC;
				S_T_ACC: begin
					if (k_last) begin
						state_q <= S_G_RD;
					end else begin
						k_q <= k_q + IDX_W'(1);
						state_q <= S_T_RD;
					end
				end
				S_G_RD:    state_q <= S_G_DIFF;
				S_G_DIFF:  state_q <= use_div ? S_D_START : S_WRITE;
				S_D_START: state_q <= S_D_WAIT;
				S_D_WAIT: begin
					if (!status.div_busy) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= S_ELEM;
					unique case (phase_q)
						PH_LU: begin
							if (j_q != nm1_q) begin
								j_q <= j_q + IDX_W'(1);
							end else if (i_q != nm1_q) begin
								i_q <= i_q + IDX_W'(1);
								j_q <= '0;
							end else begin
								phase_q <= PH_FWD;
								i_q <= IDX_W'(1);
							end
						end
						PH_FWD: begin
							if (i_q != nm1_q) begin
								i_q <= i_q + IDX_W'(1);
							end else begin
								phase_q <= PH_BCK;
								i_q <= nm1_q;
							end
						end
						PH_BCK: begin
							if (i_q != '0) begin
								i_q <= i_q - IDX_W'(1);
							end else begin
								state_q <= S_E_RD;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_E_RD: state_q <= S_E_OUT;
				S_E_OUT: begin
					if (status.out_free) begin
						if (i_q == nm1_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + IDX_W'(1);
							state_q <= S_E_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
